/* hw/rtl/ptbl_pkg.sv */
package ptbl_pkg;

	localparam int MAX_ANGLE_ROWS = 64;
	localparam int MAX_WIND_COLS = 32;
	localparam int ROW_W = $clog2(MAX_ANGLE_ROWS);
	localparam int COL_W = $clog2(MAX_WIND_COLS);
	localparam int CELL_AW = ROW_W + COL_W;
	localparam int ROWS_CNT_W = ROW_W + 1;
	localparam int COLS_CNT_W = COL_W + 1;
	localparam int VAL_W = 16;
	localparam int CFG_W = 7;

	// angle arithmetic in 1/256 degree
	localparam logic [16:0] FULL_TURN_S = 17'd92160;
	localparam logic [16:0] HALF_TURN = 17'd46080;
	// offset left behind when the sign bit is flipped to bias the angle
	localparam logic [16:0] NEG_BIAS = 17'((longint'(1) << 31) % 92160);
	// full turn is 45 * 2^11; 2^12 is 1 mod 45, reciprocal of 45 in Q0.20
	localparam logic [27:0] MOD45_RECIP = 28'd23302;
	localparam logic [12:0] MOD45_DIV = 13'd45;
	localparam logic [16:0] ONE_FRAC = 17'h10000;
	localparam logic [48:0] ROUND_HALF = 49'h0_8000_0000;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef enum logic [1:0] {
		CMD_WR_ANGLE,
		CMD_WR_WIND,
		CMD_WR_CELL,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [VAL_W-1:0]   value;
		logic signed [31:0] angle;
		logic [VAL_W-1:0]   wind;
	} cmd_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] speed;
		logic             tbl_empty;
	} res_t;

endpackage

/* hw/rtl/ptbl_ram.sv */
module ptbl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/ptbl_front.sv */
module ptbl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 func,
	input  logic [ptbl_pkg::ROW_W-1:0] row_index,
	input  logic [ptbl_pkg::COL_W-1:0] col_index,
	input  logic [ptbl_pkg::VAL_W-1:0] table_value,
	input  logic signed [31:0]         query_angle,
	input  logic [ptbl_pkg::VAL_W-1:0] query_wind,
	output logic                       head_valid,
	output ptbl_pkg::cmd_t             head,
	input  logic                       head_pop
);

	localparam logic [1:0] FUNC_WR_ANGLE = 2'd0;
	localparam logic [1:0] FUNC_WR_WIND = 2'd1;
	localparam logic [1:0] FUNC_WR_CELL = 2'd2;

	ptbl_pkg::cmd_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	ptbl_pkg::cmd_t cmd_in;
	logic           do_push;
	logic           do_pop;

	// classify the incoming item
	always_comb begin
		cmd_in.row = row_index;
		cmd_in.col = col_index;
		cmd_in.value = table_value;
		cmd_in.angle = query_angle;
		cmd_in.wind = query_wind;
		case (func)
			FUNC_WR_ANGLE: cmd_in.kind = ptbl_pkg::CMD_WR_ANGLE;
			FUNC_WR_WIND:  cmd_in.kind = ptbl_pkg::CMD_WR_WIND;
			FUNC_WR_CELL:  cmd_in.kind = ptbl_pkg::CMD_WR_CELL;
			default:       cmd_in.kind = ptbl_pkg::CMD_QUERY;
		endcase
	end

	assign full = cnt_q[1];
	assign head_valid = (cnt_q != 2'd0);
	assign head = q_mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* hw/rtl/ptbl_engine.sv */
module ptbl_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [6:0]            angle_rows_used,
	input  logic [5:0]            wind_cols_used,
	input  logic                  head_valid,
	input  ptbl_pkg::cmd_t        head,
	output logic                  head_pop,
	output ptbl_pkg::res_t        res,
	input  logic                  out_free
);

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_FOLD, S_RD_LO, S_CLAMP_LO, S_CLAMP_HI, S_SCAN_RD,
		S_SCAN_CHK, S_BR_LO, S_BR_HI, S_BR_GET, S_FRAC, S_DIV, S_CELL,
		S_MAC, S_RESULT
	} state_t;

	state_t                              state_q;
	logic [32:0]                         x_q;
	logic [3:0]                          cnt_q;
	logic [ptbl_pkg::VAL_W-1:0]          xa_q, xw_q;
	logic [ptbl_pkg::VAL_W-1:0]          loa_q, low_q, hia_q, hiw_q;
	logic [ptbl_pkg::ROW_W-1:0]          ka_q;
	logic [ptbl_pkg::COL_W-1:0]          kw_q;
	logic                                da_q, dw_q;
	logic                                sel_q;
	logic [ptbl_pkg::VAL_W-1:0]          rem_q, gap_q, quo_q;
	logic [16:0]                         fa_q, fw_q;
	logic [1:0]                          corner_q;
	logic [33:0]                         wt_q;
	logic [48:0]                         acc_q;
	logic                                tbl_empty_q;

	logic [ptbl_pkg::ROWS_CNT_W-1:0]     nr;
	logic [ptbl_pkg::COLS_CNT_W-1:0]     nc;
	logic [ptbl_pkg::ROW_W-1:0]          i2a, a_raddr;
	logic [ptbl_pkg::COL_W-1:0]          i2w, w_raddr;
	logic [ptbl_pkg::CELL_AW-1:0]        c_raddr;
	logic [ptbl_pkg::VAL_W-1:0]          a_rdata, w_rdata, c_rdata;
	logic                                a_we, w_we, c_we;
	logic [12:0]                         csum, cfold, r45;
	logic [27:0]                         qprod;
	logic [16:0]                         unb, folded;
	logic                                da_n, dw_n;
	logic signed [17:0]                  num, gap;
	logic [16:0]                         r2;
	logic                                ge;
	logic [ptbl_pkg::VAL_W-1:0]          quo_n;
	logic [16:0]                         wa, ww;

	// used counts saturate at the table size
	assign nr = (angle_rows_used > 7'(ptbl_pkg::MAX_ANGLE_ROWS))
		? ptbl_pkg::ROWS_CNT_W'(ptbl_pkg::MAX_ANGLE_ROWS)
		: ptbl_pkg::ROWS_CNT_W'(angle_rows_used);
	assign nc = (wind_cols_used > 6'(ptbl_pkg::MAX_WIND_COLS))
		? ptbl_pkg::COLS_CNT_W'(ptbl_pkg::MAX_WIND_COLS)
		: ptbl_pkg::COLS_CNT_W'(wind_cols_used);

	assign i2a = (nr > ptbl_pkg::ROWS_CNT_W'(1)) ? ka_q + 1'b1 : ka_q;
	assign i2w = (nc > ptbl_pkg::COLS_CNT_W'(1)) ? kw_q + 1'b1 : kw_q;

	assign head_pop = head_valid && (state_q == S_IDLE);
	assign a_we = head_pop && (head.kind == ptbl_pkg::CMD_WR_ANGLE);
	assign w_we = head_pop && (head.kind == ptbl_pkg::CMD_WR_WIND);
	assign c_we = head_pop && (head.kind == ptbl_pkg::CMD_WR_CELL);

	// read addresses follow the state; data is used one state later
	always_comb begin
		a_raddr = '0;
		w_raddr = '0;
		c_raddr = {(corner_q[0] ? i2a : ka_q), (corner_q[1] ? i2w : kw_q)};
		case (state_q)
			S_CLAMP_LO: begin
				a_raddr = ptbl_pkg::ROW_W'(nr - 1'b1);
				w_raddr = ptbl_pkg::COL_W'(nc - 1'b1);
			end
			S_SCAN_RD: begin
				a_raddr = ka_q + 1'b1;
				w_raddr = kw_q + 1'b1;
			end
			S_BR_LO: begin
				a_raddr = ka_q;
				w_raddr = kw_q;
			end
			S_BR_HI: begin
				a_raddr = i2a;
				w_raddr = i2w;
			end
			default: begin
				a_raddr = '0;
				w_raddr = '0;
			end
		endcase
	end

	ptbl_ram #(.WIDTH(ptbl_pkg::VAL_W), .DEPTH(ptbl_pkg::MAX_ANGLE_ROWS)) u_angle_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (head.row),
		.wdata (head.value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	ptbl_ram #(.WIDTH(ptbl_pkg::VAL_W), .DEPTH(ptbl_pkg::MAX_WIND_COLS)) u_wind_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (head.col),
		.wdata (head.value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	ptbl_ram #(
		.WIDTH(ptbl_pkg::VAL_W),
		.DEPTH(ptbl_pkg::MAX_ANGLE_ROWS * ptbl_pkg::MAX_WIND_COLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr ({head.row, head.col}),
		.wdata (head.value),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// datapath helpers
	always_comb begin
		// turn reduction: low 11 bits pass, upper part is reduced mod 45
		csum = 13'(x_q[22:11]) + 13'(x_q[31:23]);
		cfold = 13'(csum[11:0]) + 13'(csum[12]);
		qprod = 28'(x_q[23:11]) * ptbl_pkg::MOD45_RECIP;
		r45 = x_q[23:11] - 13'(qprod[26:20] * ptbl_pkg::MOD45_DIV);
		unb = (x_q[16:0] >= ptbl_pkg::NEG_BIAS) ? x_q[16:0] - ptbl_pkg::NEG_BIAS
			: x_q[16:0] + (ptbl_pkg::FULL_TURN_S - ptbl_pkg::NEG_BIAS);
		folded = (unb > ptbl_pkg::HALF_TURN) ? ptbl_pkg::FULL_TURN_S - unb : unb;

		da_n = da_q;
		if (!da_q) begin
			if (xa_q < a_rdata) begin
				da_n = 1'b1;
			end else if ({1'b0, ka_q} + ptbl_pkg::ROWS_CNT_W'(3) >= nr) begin
				da_n = 1'b1;
			end
		end
		dw_n = dw_q;
		if (!dw_q) begin
			if (xw_q < w_rdata) begin
				dw_n = 1'b1;
			end else if ({1'b0, kw_q} + ptbl_pkg::COLS_CNT_W'(3) >= nc) begin
				dw_n = 1'b1;
			end
		end

		num = sel_q ? 18'(signed'({2'b0, xw_q})) - 18'(signed'({2'b0, low_q}))
			: 18'(signed'({2'b0, xa_q})) - 18'(signed'({2'b0, loa_q}));
		gap = sel_q ? 18'(signed'({2'b0, hiw_q})) - 18'(signed'({2'b0, low_q}))
			: 18'(signed'({2'b0, hia_q})) - 18'(signed'({2'b0, loa_q}));

		r2 = {rem_q, 1'b0};
		ge = (r2 >= {1'b0, gap_q});
		quo_n = {quo_q[ptbl_pkg::VAL_W-2:0], ge};

		wa = corner_q[0] ? fa_q : ptbl_pkg::ONE_FRAC - fa_q;
		ww = corner_q[1] ? fw_q : ptbl_pkg::ONE_FRAC - fw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			sel_q <= 1'b0;
			corner_q <= '0;
			da_q <= 1'b0;
			dw_q <= 1'b0;
			tbl_empty_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head_pop && head.kind == ptbl_pkg::CMD_QUERY) begin
						x_q <= {1'b0, ~head.angle[31], head.angle[30:0]};
						xw_q <= head.wind;
						cnt_q <= 4'd1;
						acc_q <= '0;
						sel_q <= 1'b0;
						corner_q <= '0;
						tbl_empty_q <= (nr == '0) || (nc == '0);
						state_q <= ((nr == '0) || (nc == '0)) ? S_RESULT : S_MOD;
					end
				end
				S_MOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 4'd0) begin
						x_q <= {16'b0, r45[5:0], x_q[10:0]};
						state_q <= S_FOLD;
					end else begin
						x_q <= {9'b0, cfold, x_q[10:0]};
					end
				end
				S_FOLD: begin
					xa_q <= folded[ptbl_pkg::VAL_W-1:0];
					state_q <= S_RD_LO;
				end
				S_RD_LO: begin
					state_q <= S_CLAMP_LO;
				end
				S_CLAMP_LO: begin
					if (xa_q < a_rdata) begin
						xa_q <= a_rdata;
					end
					if (xw_q < w_rdata) begin
						xw_q <= w_rdata;
					end
					state_q <= S_CLAMP_HI;
				end
				S_CLAMP_HI: begin
					if (xa_q > a_rdata) begin
						xa_q <= a_rdata;
					end
					if (xw_q > w_rdata) begin
						xw_q <= w_rdata;
					end
					ka_q <= '0;
					kw_q <= '0;
					da_q <= (nr <= ptbl_pkg::ROWS_CNT_W'(2));
					dw_q <= (nc <= ptbl_pkg::COLS_CNT_W'(2));
					if ((nr <= ptbl_pkg::ROWS_CNT_W'(2)) && (nc <= ptbl_pkg::COLS_CNT_W'(2))) begin
						state_q <= S_BR_LO;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (!da_q && !(xa_q < a_rdata)) begin
						ka_q <= ka_q + 1'b1;
					end
					if (!dw_q && !(xw_q < w_rdata)) begin
						kw_q <= kw_q + 1'b1;
					end
					da_q <= da_n;
					dw_q <= dw_n;
					state_q <= (da_n && dw_n) ? S_BR_LO : S_SCAN_RD;
				end
				S_BR_LO: begin
					state_q <= S_BR_HI;
				end
				S_BR_HI: begin
					loa_q <= a_rdata;
					low_q <= w_rdata;
					state_q <= S_BR_GET;
				end
				S_BR_GET: begin
					hia_q <= a_rdata;
					hiw_q <= w_rdata;
					state_q <= S_FRAC;
				end
				S_FRAC: begin
					if (gap <= 18'sd0 || num <= 18'sd0 || num >= gap) begin
						if (sel_q) begin
							fw_q <= (gap <= 18'sd0 || num <= 18'sd0) ? '0 : ptbl_pkg::ONE_FRAC;
							state_q <= S_CELL;
						end else begin
							fa_q <= (gap <= 18'sd0 || num <= 18'sd0) ? '0 : ptbl_pkg::ONE_FRAC;
							sel_q <= 1'b1;
						end
					end else begin
						rem_q <= num[ptbl_pkg::VAL_W-1:0];
						gap_q <= gap[ptbl_pkg::VAL_W-1:0];
						quo_q <= '0;
						cnt_q <= 4'd15;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? 16'(r2 - {1'b0, gap_q}) : r2[ptbl_pkg::VAL_W-1:0];
					quo_q <= quo_n;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 4'd0) begin
						if (sel_q) begin
							fw_q <= {1'b0, quo_n};
							state_q <= S_CELL;
						end else begin
							fa_q <= {1'b0, quo_n};
							sel_q <= 1'b1;
							state_q <= S_FRAC;
						end
					end
				end
				S_CELL: begin
					wt_q <= 34'(wa * ww);
					state_q <= S_MAC;
				end
				S_MAC: begin
					acc_q <= acc_q + 49'(wt_q * c_rdata);
					corner_q <= corner_q + 1'b1;
					state_q <= (corner_q == 2'd3) ? S_RESULT : S_CELL;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic [48:0] rounded;
	assign rounded = acc_q + ptbl_pkg::ROUND_HALF;
	assign res.valid = (state_q == S_RESULT);
	assign res.speed = rounded[32 +: ptbl_pkg::VAL_W];
	assign res.tbl_empty = tbl_empty_q;

endmodule

/* hw/rtl/polar_table_bilinear_lookup.sv */
// Sequencing: the engine takes a table write straight from idle; a query runs through the
//   2-step angle reduction, the serial bracket scan and up to two 16-step fraction divides.
// Concurrency: one item at a time in the engine; a 2-entry input queue and a 1-entry
//   result register let both sides run while it works.
// Reset: arst_n asynchronous active low clears control and the used counts; table
//   memories are not cleared.
module polar_table_bilinear_lookup (
	input  logic                       clk,
	input  logic                       arst_n,
	// input queue side
	input  logic                       push,
	output logic                       full,
	input  logic [1:0]                 func,
	input  logic [ptbl_pkg::ROW_W-1:0] row_index,
	input  logic [ptbl_pkg::COL_W-1:0] col_index,
	input  logic [ptbl_pkg::VAL_W-1:0] table_value,
	input  logic signed [31:0]         query_angle,
	input  logic [ptbl_pkg::VAL_W-1:0] query_wind,
	// result queue side
	output logic                       empty,
	input  logic                       pop,
	output logic [ptbl_pkg::VAL_W-1:0] boat_speed,
	output logic                       table_empty,
	// configuration writes
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [ptbl_pkg::CFG_W-1:0] cfg_wdata
);

	logic           head_valid;
	logic           head_pop;
	ptbl_pkg::cmd_t head;
	ptbl_pkg::res_t res;
	logic           out_free;

	logic [6:0]                 rows_used_q;
	logic [5:0]                 cols_used_q;
	logic                       out_v_q;
	logic [ptbl_pkg::VAL_W-1:0] speed_q;
	logic                       tbl_empty_q;

	// config registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= '0;
			cols_used_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ptbl_pkg::CFG_ROWS: rows_used_q <= cfg_wdata;
				ptbl_pkg::CFG_COLS: cols_used_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// front: queue and classify incoming items
	ptbl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.row_index   (row_index),
		.col_index   (col_index),
		.table_value (table_value),
		.query_angle (query_angle),
		.query_wind  (query_wind),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop)
	);

	// back: table memories and the query sequencer
	ptbl_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.angle_rows_used (rows_used_q),
		.wind_cols_used  (cols_used_q),
		.head_valid      (head_valid),
		.head            (head),
		.head_pop        (head_pop),
		.res             (res),
		.out_free        (out_free)
	);

	// result register; refilled in the cycle it is popped
	assign out_free = !out_v_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res.valid && out_free) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			speed_q <= res.speed;
			tbl_empty_q <= res.tbl_empty;
		end
	end

	assign empty = !out_v_q;
	assign boat_speed = speed_q;
	assign table_empty = tbl_empty_q;

	// a finished result waits in the engine until the register frees up
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !out_free |=> res.valid)
		else $error("result dropped while output register busy");

	// an empty table always reports zero speed
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && table_empty |-> boat_speed == '0)
		else $error("nonzero speed on empty table");

	// engine takes an item only when one is queued
	assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_valid)
		else $error("pop from empty input queue");

endmodule

/* sim/polar_table_checker.sv */
module polar_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic [1:0]                 func,
	input  logic [ptbl_pkg::ROW_W-1:0] row_index,
	input  logic [ptbl_pkg::COL_W-1:0] col_index,
	input  logic [ptbl_pkg::VAL_W-1:0] table_value,
	input  logic signed [31:0]         query_angle,
	input  logic [ptbl_pkg::VAL_W-1:0] query_wind,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [ptbl_pkg::VAL_W-1:0] boat_speed,
	input  logic                       table_empty,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [ptbl_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       drain_check,
	output int                         errors
);

	typedef struct {
		logic [15:0] speed;
		logic        is_empty;
	} speed_result_t;

	logic [15:0]   angle_tab [ptbl_pkg::MAX_ANGLE_ROWS];
	logic [15:0]   wind_tab [ptbl_pkg::MAX_WIND_COLS];
	logic [15:0]   cell_tab [ptbl_pkg::MAX_ANGLE_ROWS*ptbl_pkg::MAX_WIND_COLS];
	int            rows_cfg;
	int            cols_cfg;
	speed_result_t pending_speeds[$];
	bit            drained;

	// Q0.16 fraction, floor, held on 0..65536
	function automatic longint frac16(longint x, longint lo, longint hi);
		longint gap;
		longint num;
		gap = hi - lo;
		num = x - lo;
		if (gap <= 0 || num <= 0)
			return 0;
		if (num >= gap)
			return 65536;
		return (num * 65536) / gap;
	endfunction

	function automatic logic [15:0] interp_speed(longint angle, longint wind, int nr, int nc);
		longint a;
		longint w;
		int     i;
		int     i2;
		int     j;
		int     j2;
		longint fa;
		longint fw;
		longint unsigned sum;
		a = angle % 92160;
		w = wind;
		if (a < 0)
			a += 92160;
		if (a > 46080)
			a = 92160 - a;
		if (a < angle_tab[0])
			a = angle_tab[0];
		if (a > angle_tab[nr-1])
			a = angle_tab[nr-1];
		if (w < wind_tab[0])
			w = wind_tab[0];
		if (w > wind_tab[nc-1])
			w = wind_tab[nc-1];
		i = (nr < 2) ? 0 : nr - 2;
		for (int k = 0; k + 2 < nr; k++) begin
			if (a < angle_tab[k+1]) begin
				i = k;
				break;
			end
		end
		j = (nc < 2) ? 0 : nc - 2;
		for (int k = 0; k + 2 < nc; k++) begin
			if (w < wind_tab[k+1]) begin
				j = k;
				break;
			end
		end
		i2 = (nr > 1) ? i + 1 : i;
		j2 = (nc > 1) ? j + 1 : j;
		fa = frac16(a, angle_tab[i], angle_tab[i2]);
		fw = frac16(w, wind_tab[j], wind_tab[j2]);
		sum = longint'(65536 - fa) * (65536 - fw) * cell_tab[i*ptbl_pkg::MAX_WIND_COLS + j]
			+ longint'(fa) * (65536 - fw) * cell_tab[i2*ptbl_pkg::MAX_WIND_COLS + j]
			+ longint'(65536 - fa) * fw * cell_tab[i*ptbl_pkg::MAX_WIND_COLS + j2]
			+ longint'(fa) * fw * cell_tab[i2*ptbl_pkg::MAX_WIND_COLS + j2];
		sum = (sum + 64'h8000_0000) >> 32;
		return sum[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		speed_result_t exp_r;
		speed_result_t got_r;
		int nr;
		int nc;
		if (!arst_n) begin
			rows_cfg = 0;
			cols_cfg = 0;
			errors = 0;
			drained = 0;
			pending_speeds.delete();
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == ptbl_pkg::CFG_ROWS)
					rows_cfg = cfg_wdata & 7'h7F;
				else
					cols_cfg = cfg_wdata & 7'h3F;
			end
			if (pop && !empty) begin
				if (pending_speeds.size() == 0) begin
					$display("%0t unexpected result: boat_speed %0d table_empty %0b",
						$time, boat_speed, table_empty);
					errors++;
				end else begin
					exp_r = pending_speeds.pop_front();
					if (boat_speed !== exp_r.speed) begin
						$display("%0t boat_speed expected %0d actual %0d",
							$time, exp_r.speed, boat_speed);
						errors++;
					end
					if (table_empty !== exp_r.is_empty) begin
						$display("%0t table_empty expected %0b actual %0b",
							$time, exp_r.is_empty, table_empty);
						errors++;
					end
				end
			end
			if (push && !full) begin
				case (ptbl_pkg::cmd_kind_t'(func))
					ptbl_pkg::CMD_WR_ANGLE: angle_tab[row_index] = table_value;
					ptbl_pkg::CMD_WR_WIND:  wind_tab[col_index] = table_value;
					ptbl_pkg::CMD_WR_CELL:
						cell_tab[row_index*ptbl_pkg::MAX_WIND_COLS + col_index] = table_value;
					default: begin
						nr = (rows_cfg > ptbl_pkg::MAX_ANGLE_ROWS)
							? ptbl_pkg::MAX_ANGLE_ROWS : rows_cfg;
						nc = (cols_cfg > ptbl_pkg::MAX_WIND_COLS)
							? ptbl_pkg::MAX_WIND_COLS : cols_cfg;
						if (nr == 0 || nc == 0) begin
							got_r.speed = 16'd0;
							got_r.is_empty = 1'b1;
						end else begin
							got_r.speed = interp_speed(query_angle, query_wind, nr, nc);
							got_r.is_empty = 1'b0;
						end
						pending_speeds.push_back(got_r);
					end
				endcase
			end
			if (drain_check && !drained) begin
				drained = 1;
				if (pending_speeds.size() != 0) begin
					$display("%0t %0d expected results never arrived",
						$time, pending_speeds.size());
					errors += pending_speeds.size();
				end
			end
		end
	end

endmodule

/* sim/tb_polar_table_bilinear_lookup.sv */
module tb_polar_table_bilinear_lookup;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [1:0]  func = 2'd0;
	logic [5:0]  row_index = '0;
	logic [4:0]  col_index = '0;
	logic [15:0] table_value = '0;
	logic signed [31:0] query_angle = '0;
	logic [15:0] query_wind = '0;
	logic        pop = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        drain_check = 1'b0;
	logic        full;
	logic        empty;
	logic [15:0] boat_speed;
	logic        table_empty;
	int          errors;

	// bookkeeping of what the stimulus has sent and drained
	int items_sent = 0;
	int queries_sent = 0;
	int speeds_popped = 0;
	int phase_count = 0;
	// cells written since reset; queries only ever read written entries
	bit cell_set [ptbl_pkg::MAX_ANGLE_ROWS][ptbl_pkg::MAX_WIND_COLS];
	// current axis contents, to aim queries near entries
	logic [15:0] angle_shadow [ptbl_pkg::MAX_ANGLE_ROWS];
	logic [15:0] wind_shadow [ptbl_pkg::MAX_WIND_COLS];
	int eff_rows = 0;
	int eff_cols = 0;

	always #10 clk = ~clk;

	polar_table_bilinear_lookup u_dut (
		.clk, .arst_n, .push, .full, .func, .row_index, .col_index, .table_value,
		.query_angle, .query_wind, .empty, .pop, .boat_speed, .table_empty,
		.cfg_wr_en, .cfg_index, .cfg_wdata
	);

	polar_table_checker u_checker (
		.clk, .arst_n, .push, .full, .func, .row_index, .col_index, .table_value,
		.query_angle, .query_wind, .empty, .pop, .boat_speed, .table_empty,
		.cfg_wr_en, .cfg_index, .cfg_wdata, .drain_check, .errors
	);

	// send one item; push stays high across back-to-back items
	task automatic send_item(ptbl_pkg::cmd_kind_t k, int r, int c, int v, int a, int w);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0; // stretches with no idling
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= k;
		row_index <= r[5:0];
		col_index <= c[4:0];
		table_value <= v[15:0];
		query_angle <= a;
		query_wind <= w[15:0];
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		if (k == ptbl_pkg::CMD_QUERY)
			queries_sent++;
		if (k == ptbl_pkg::CMD_WR_ANGLE)
			angle_shadow[r] = v[15:0];
		if (k == ptbl_pkg::CMD_WR_WIND)
			wind_shadow[c] = v[15:0];
		if (k == ptbl_pkg::CMD_WR_CELL)
			cell_set[r][c] = 1;
	endtask

	// sender holds off until every result is back, then lets the engine settle;
	// the last item was taken at the edge just passed, so push drops right away
	task automatic drain_all();
		push <= 1'b0;
		while (speeds_popped != queries_sent)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic set_counts(int rows, int cols);
		drain_all();
		cfg_wr_en <= 1'b1;
		cfg_index <= ptbl_pkg::CFG_ROWS;
		cfg_wdata <= rows[6:0];
		@(posedge clk);
		cfg_index <= ptbl_pkg::CFG_COLS;
		cfg_wdata <= cols[6:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		eff_rows = (rows > ptbl_pkg::MAX_ANGLE_ROWS) ? ptbl_pkg::MAX_ANGLE_ROWS : rows;
		eff_cols = (cols > ptbl_pkg::MAX_WIND_COLS) ? ptbl_pkg::MAX_WIND_COLS : cols;
		phase_count++;
	endtask

	// fresh ascending axes (with some flat steps) and any missing cells
	task automatic load_table();
		int v;
		int step_max;
		v = $urandom_range(0, 3000);
		step_max = 62000 / (eff_rows + 1);
		for (int r = 0; r < eff_rows; r++) begin
			send_item(ptbl_pkg::CMD_WR_ANGLE, r, 0, v, 0, 0);
			v += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, step_max);
		end
		v = $urandom_range(0, 2000);
		step_max = 62000 / (eff_cols + 1);
		for (int c = 0; c < eff_cols; c++) begin
			send_item(ptbl_pkg::CMD_WR_WIND, 0, c, v, 0, 0);
			v += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, step_max);
		end
		for (int r = 0; r < eff_rows; r++)
			for (int c = 0; c < eff_cols; c++)
				if (!cell_set[r][c])
					send_item(ptbl_pkg::CMD_WR_CELL, r, c, $urandom_range(0, 65535), 0, 0);
	endtask

	task automatic random_query();
		int a;
		int w;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			a = $urandom();
		else if (pick < 7)
			a = $urandom_range(0, 92159);
		else if (eff_rows > 0)
			a = angle_shadow[$urandom_range(0, eff_rows - 1)] + $urandom_range(0, 4) - 2;
		else
			a = $urandom_range(0, 46080);
		if ($urandom_range(0, 3) == 0)
			a = -a;
		pick = $urandom_range(0, 9);
		if (pick < 4 || eff_cols == 0)
			w = $urandom_range(0, 65535);
		else if (pick < 8)
			w = $urandom_range(wind_shadow[0], wind_shadow[eff_cols - 1]);
		else
			w = wind_shadow[$urandom_range(0, eff_cols - 1)];
		send_item(ptbl_pkg::CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 31),
			$urandom_range(0, 65535), a, w);
	endtask

	// result side: random stall before each pop
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0)
				wait_n = 0;
			if (wait_n > 0) begin
				pop <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			speeds_popped++;
		end
	end

	// watchdog
	initial begin
		#60000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int rows_pick;
		int cols_pick;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table after reset, and with only one count set
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 32'sh7FFF_FFFF, 16'hFFFF);
		set_counts(2, 0);
		send_item(ptbl_pkg::CMD_QUERY, 63, 31, 65535, 32'sh8000_0000, 0);

		// directed: 3x3 table, fold, clamps and extreme fields
		set_counts(3, 3);
		send_item(ptbl_pkg::CMD_WR_ANGLE, 0, 0, 7680, 0, 0);
		send_item(ptbl_pkg::CMD_WR_ANGLE, 1, 0, 23040, 0, 0);
		send_item(ptbl_pkg::CMD_WR_ANGLE, 2, 0, 38400, 0, 0);
		send_item(ptbl_pkg::CMD_WR_WIND, 0, 0, 1280, 0, 0);
		send_item(ptbl_pkg::CMD_WR_WIND, 1, 0, 2560, 0, 0);
		send_item(ptbl_pkg::CMD_WR_WIND, 2, 0, 5120, 0, 0);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_item(ptbl_pkg::CMD_WR_CELL, r, c,
					(r == 2 && c == 2) ? 65535 : r * 700 + c * 300, 0, 0);
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 15360, 1920);        // interior
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, -15360, 1920);       // negative angle
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 92160 - 30000, 3000); // folded past 180
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 32'sh7FFF_FFFF, 65535); // wind top clamp
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 32'sh8000_0000, 0);     // wind bottom clamp
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 46080, 5120);
		// single-entry axes
		set_counts(1, 1);
		send_item(ptbl_pkg::CMD_QUERY, 0, 0, 0, 20000, 2000);

		// random phases over several count settings
		while (items_sent < 560) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: rows_pick = 0;
				1: rows_pick = 1;
				2: rows_pick = 64;
				3: rows_pick = $urandom_range(65, 127); // acts as the maximum
				default: rows_pick = $urandom_range(2, 12);
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: cols_pick = (rows_pick == 0) ? 3 : 0;
				1: cols_pick = 1;
				2: cols_pick = 32;
				3: cols_pick = $urandom_range(33, 63);
				default: cols_pick = $urandom_range(2, 10);
			endcase
			// keep the cell fill small: a long axis goes with a short one
			if (rows_pick >= 64 && cols_pick > 4)
				cols_pick = $urandom_range(1, 4);
			else if (cols_pick >= 32 && rows_pick > 4)
				rows_pick = $urandom_range(1, 4);
			set_counts(rows_pick, cols_pick);
			load_table();
			for (int n = 0; n < 45; n++) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					random_query();
				else if (pick < 18)
					send_item(ptbl_pkg::CMD_WR_CELL, $urandom_range(0, 63),
						$urandom_range(0, 31), $urandom_range(0, 65535), $urandom(), $urandom());
				else if (pick == 18)
					// breaks ordering of the angle axis on purpose
					send_item(ptbl_pkg::CMD_WR_ANGLE, $urandom_range(0, 63),
						$urandom_range(0, 31), $urandom_range(0, 65535), $urandom(), $urandom());
				else
					send_item(ptbl_pkg::CMD_WR_WIND, $urandom_range(0, 63),
						$urandom_range(0, 31), $urandom_range(0, 65535), $urandom(), $urandom());
			end
		end

		drain_all();
		drain_check <= 1'b1;
		repeat (2) @(posedge clk);
		$display("covered %0d queries in %0d items over %0d count settings, incl. empty,",
			queries_sent, items_sent, phase_count);
		$display("single-entry and oversized counts, folded and clamped angles, unordered axes");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
